// ===== rtl/mgmb_pkg.sv =====
// ----------------------------------------------------------------------------
// mgmb_pkg: shared types and constants of the masked ground map blitter
// Map geometry, field widths, ground codes, commands and the queue word
// passed from the front end to the back end.
// ----------------------------------------------------------------------------
package mgmb_pkg;

  // map store geometry
  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 1024;
  localparam int TYPE_BITS  = 4;

  // fixed field widths
  localparam int DIM_W = 11;          // map_width / map_height registers
  localparam int ORG_W = 12;          // origin_x / origin_y, signed
  localparam int OFF_W = 10;          // off_x / off_y
  localparam int GT_W  = 4;           // ground_type / pixel_type
  localparam int CNT_W = 32;          // change counter
  localparam int CFG_IDX_W = 1;

  // derived widths
  localparam int CO_W      = ORG_W + 1;                // origin + offset
  localparam int XW        = $clog2(MAX_WIDTH);
  localparam int YW        = $clog2(MAX_HEIGHT);
  localparam int EW_X      = $clog2(MAX_WIDTH + 1);
  localparam int EW_Y      = $clog2(MAX_HEIGHT + 1);
  localparam int EW_M      = (EW_X > EW_Y) ? EW_X : EW_Y;
  localparam int CMP_W     = (EW_M > ORG_W) ? EW_M : ORG_W;
  localparam int MAP_DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int ADDR_W    = $clog2(MAP_DEPTH);
  localparam int PROD_W    = YW + EW_X;

  // front-to-back queue
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);
  localparam int OCC_W  = $clog2(QDEPTH + 3);

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_MAP_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_MAP_HEIGHT = 1'b1;
  localparam logic [DIM_W-1:0]     MAP_DIM_RESET  = 11'd1024;

  // ground codes
  localparam logic [GT_W-1:0] GT_EMPTY       = 4'd0;
  localparam logic [GT_W-1:0] GT_SOLID       = 4'd1;
  localparam logic [GT_W-1:0] GT_BRIDGE      = 4'd2;
  localparam logic [GT_W-1:0] GT_TRANSPARENT = 4'd3;
  localparam logic [GT_W-1:0] GT_OUTSIDE     = 4'd4;

  typedef enum logic [1:0] {
    CMD_READ  = 2'd0,
    CMD_SET   = 2'd1,
    CMD_PAINT = 2'd2,
    CMD_ERASE = 2'd3
  } cmd_e;

  typedef logic [TYPE_BITS-1:0] code_t;
  typedef logic [GT_W-1:0]      gt_t;
  typedef logic [ADDR_W-1:0]    addr_t;
  typedef logic [CMP_W-1:0]     cmp_t;
  typedef logic [PROD_W-1:0]    prod_t;
  typedef logic [OCC_W-1:0]     occ_t;
  typedef logic [QPTR_W-1:0]    qptr_t;
  typedef logic [QCNT_W-1:0]    qcnt_t;
  typedef logic [CNT_W-1:0]     cnt_t;
  typedef logic [EW_X-1:0]      ew_x_t;
  typedef logic [EW_Y-1:0]      ew_y_t;

  // one classified pixel access
  typedef struct packed {
    cmd_e        cmd;
    logic        in_map;
    logic        skip;     // paint: transparent, clear mask bit or origin past map
    addr_t       addr;
    gt_t         gtype;
    logic        mbit;
    logic        start;
  } q_entry_t;

endpackage

// ===== rtl/mgmb_ram.sv =====
// ----------------------------------------------------------------------------
// mgmb_ram: generic single-port RAM
// One access per cycle, write or read, read data registered.
// ----------------------------------------------------------------------------
module mgmb_ram #(
  parameter int WIDTH = 4,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end else begin
      rdata_q <= mem[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/mgmb_front.sv =====
// ----------------------------------------------------------------------------
// mgmb_front: accept and classify pixel accesses
// Stage A forms the pixel position, the in-map test and the paint skip test;
// stage B forms the store address and pushes the word into the queue.
// ----------------------------------------------------------------------------
module mgmb_front (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic [1:0]                in_cmd_i,
  input  logic [11:0]               in_origin_x_i,
  input  logic [11:0]               in_origin_y_i,
  input  logic [9:0]                in_off_x_i,
  input  logic [9:0]                in_off_y_i,
  input  logic                      in_mask_bit_i,
  input  logic [3:0]                in_ground_type_i,
  input  logic                      in_op_start_i,
  input  mgmb_pkg::ew_x_t           eff_w_i,
  input  mgmb_pkg::ew_y_t           eff_h_i,
  input  logic                      clearing_i,
  input  mgmb_pkg::qcnt_t           q_count_i,
  output logic                      q_push_o,
  output mgmb_pkg::q_entry_t        q_entry_o
);

  logic                          accept;
  mgmb_pkg::cmd_e                cmd;
  logic [mgmb_pkg::OFF_W-1:0]    dx, dy;
  logic [mgmb_pkg::CO_W-1:0]     px, py;
  logic                          in_map, ox_past, oy_past, skip;
  mgmb_pkg::occ_t                occ;
  mgmb_pkg::prod_t               prod;

  // stage A
  logic                          fa_valid_q;
  mgmb_pkg::cmd_e                fa_cmd_q;
  logic [mgmb_pkg::XW-1:0]       fa_x_q;
  logic [mgmb_pkg::YW-1:0]       fa_y_q;
  logic                          fa_in_map_q, fa_skip_q, fa_mbit_q, fa_start_q;
  mgmb_pkg::gt_t                 fa_gt_q;

  // stage B
  logic                          fb_valid_q;
  mgmb_pkg::q_entry_t            fb_q, fb_d;

  // pipe plus queue never hold more than the queue depth
  assign occ = mgmb_pkg::occ_t'(fa_valid_q) + mgmb_pkg::occ_t'(fb_valid_q)
             + mgmb_pkg::occ_t'(q_count_i);
  assign in_stall_o = clearing_i || (occ >= mgmb_pkg::occ_t'(mgmb_pkg::QDEPTH));
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    cmd = mgmb_pkg::cmd_e'(in_cmd_i);
    if (cmd == mgmb_pkg::CMD_READ || cmd == mgmb_pkg::CMD_SET) begin
      dx = '0;
      dy = '0;
    end else begin
      dx = in_off_x_i;
      dy = in_off_y_i;
    end
    px = {{(mgmb_pkg::CO_W - mgmb_pkg::ORG_W){in_origin_x_i[mgmb_pkg::ORG_W-1]}},
          in_origin_x_i}
       + {{(mgmb_pkg::CO_W - mgmb_pkg::OFF_W){1'b0}}, dx};
    py = {{(mgmb_pkg::CO_W - mgmb_pkg::ORG_W){in_origin_y_i[mgmb_pkg::ORG_W-1]}},
          in_origin_y_i}
       + {{(mgmb_pkg::CO_W - mgmb_pkg::OFF_W){1'b0}}, dy};
    in_map = !px[mgmb_pkg::CO_W-1] && !py[mgmb_pkg::CO_W-1]
          && (mgmb_pkg::cmp_t'(px[mgmb_pkg::CO_W-2:0]) < mgmb_pkg::cmp_t'(eff_w_i))
          && (mgmb_pkg::cmp_t'(py[mgmb_pkg::CO_W-2:0]) < mgmb_pkg::cmp_t'(eff_h_i));
    // origin equal to the size is not past the map
    ox_past = !in_origin_x_i[mgmb_pkg::ORG_W-1]
           && (mgmb_pkg::cmp_t'(in_origin_x_i[mgmb_pkg::ORG_W-2:0])
               > mgmb_pkg::cmp_t'(eff_w_i));
    oy_past = !in_origin_y_i[mgmb_pkg::ORG_W-1]
           && (mgmb_pkg::cmp_t'(in_origin_y_i[mgmb_pkg::ORG_W-2:0])
               > mgmb_pkg::cmp_t'(eff_h_i));
    skip = (in_ground_type_i == mgmb_pkg::GT_TRANSPARENT) || !in_mask_bit_i
        || ox_past || oy_past;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fa_valid_q <= 1'b0;
      fb_valid_q <= 1'b0;
    end else begin
      fa_valid_q <= accept;
      fb_valid_q <= fa_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      fa_cmd_q    <= cmd;
      fa_x_q      <= px[mgmb_pkg::XW-1:0];
      fa_y_q      <= py[mgmb_pkg::YW-1:0];
      fa_in_map_q <= in_map;
      fa_skip_q   <= skip;
      fa_gt_q     <= in_ground_type_i;
      fa_mbit_q   <= in_mask_bit_i;
      fa_start_q  <= in_op_start_i;
    end
    if (fa_valid_q) begin
      fb_q <= fb_d;
    end
  end

  // entry = x + y * W
  always_comb begin
    prod        = mgmb_pkg::prod_t'(fa_y_q) * mgmb_pkg::prod_t'(eff_w_i);
    fb_d.cmd    = fa_cmd_q;
    fb_d.in_map = fa_in_map_q;
    fb_d.skip   = fa_skip_q;
    fb_d.addr   = mgmb_pkg::addr_t'(prod) + mgmb_pkg::addr_t'(fa_x_q);
    fb_d.gtype  = fa_gt_q;
    fb_d.mbit   = fa_mbit_q;
    fb_d.start  = fa_start_q;
  end

  assign q_push_o  = fb_valid_q;
  assign q_entry_o = fb_q;

endmodule

// ===== rtl/mgmb_queue.sv =====
// ----------------------------------------------------------------------------
// mgmb_queue: short FIFO between front end and back end
// Register file with read and write pointers; head word shown directly.
// ----------------------------------------------------------------------------
module mgmb_queue (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  mgmb_pkg::q_entry_t  push_entry_i,
  input  logic                pop_i,
  output logic                valid_o,
  output mgmb_pkg::q_entry_t  head_o,
  output mgmb_pkg::qcnt_t     count_o
);

  mgmb_pkg::q_entry_t slots [mgmb_pkg::QDEPTH];
  mgmb_pkg::qptr_t    wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  mgmb_pkg::qcnt_t    count_q, count_d;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == mgmb_pkg::qptr_t'(mgmb_pkg::QDEPTH - 1)) ? '0
               : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == mgmb_pkg::qptr_t'(mgmb_pkg::QDEPTH - 1)) ? '0
               : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slots[wr_ptr_q] <= push_entry_i;
    end
  end

  assign valid_o = (count_q != '0);
  assign head_o  = slots[rd_ptr_q];
  assign count_o = count_q;

endmodule

// ===== rtl/mgmb_back.sv =====
// ----------------------------------------------------------------------------
// mgmb_back: map store, read-modify-write and change counter
// Clears the store after reset, then runs each queued access as a read
// cycle followed by a decide-and-write cycle into the output register.
// ----------------------------------------------------------------------------
module mgmb_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                q_valid_i,
  input  mgmb_pkg::q_entry_t  q_head_i,
  output logic                q_pop_o,
  output logic                clearing_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [3:0]          out_pixel_type_o,
  output logic                out_wrote_o,
  output logic [31:0]         out_change_count_o
);

  typedef enum logic [2:0] {
    ST_CLR  = 3'b001,
    ST_IDLE = 3'b010,
    ST_EXE  = 3'b100
  } back_state_e;

  back_state_e        state_q, state_d;
  mgmb_pkg::addr_t    clr_q, clr_d;
  mgmb_pkg::q_entry_t ex_q;
  mgmb_pkg::cnt_t     cnt_q, cnt_d;

  logic               out_valid_q, out_valid_d, out_taken;
  mgmb_pkg::gt_t      out_type_q;
  logic               out_wrote_q;

  logic               ram_we;
  mgmb_pkg::addr_t    ram_addr;
  mgmb_pkg::code_t    ram_wdata, ram_rdata;

  mgmb_pkg::code_t    old_code, wr_code;
  logic               wr_en, bump, ok_bridge;

  mgmb_ram #(
    .WIDTH(mgmb_pkg::TYPE_BITS),
    .DEPTH(mgmb_pkg::MAP_DEPTH)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .addr_i (ram_addr),
    .wdata_i(ram_wdata),
    .rdata_o(ram_rdata)
  );

  assign out_taken = out_valid_q && !out_stall_i;
  assign q_pop_o   = (state_q == ST_IDLE) && q_valid_i && (!out_valid_q || out_taken);

  // decide on the word in flight
  always_comb begin
    old_code  = ex_q.in_map ? ram_rdata : mgmb_pkg::code_t'(mgmb_pkg::GT_OUTSIDE);
    wr_code   = mgmb_pkg::code_t'(ex_q.gtype);
    wr_en     = 1'b0;
    bump      = 1'b0;
    ok_bridge = (ex_q.gtype != mgmb_pkg::GT_BRIDGE)
             || (ex_q.in_map && old_code == mgmb_pkg::code_t'(mgmb_pkg::GT_EMPTY));
    case (ex_q.cmd)
      mgmb_pkg::CMD_SET: begin
        bump  = 1'b1;
        wr_en = ex_q.in_map;
      end
      mgmb_pkg::CMD_PAINT: begin
        if (!ex_q.skip && ok_bridge) begin
          bump  = 1'b1;
          wr_en = ex_q.in_map;
        end
      end
      mgmb_pkg::CMD_ERASE: begin
        bump    = ex_q.start;
        wr_en   = ex_q.mbit && ex_q.in_map
               && (old_code != mgmb_pkg::code_t'(mgmb_pkg::GT_SOLID));
        wr_code = mgmb_pkg::code_t'(mgmb_pkg::GT_EMPTY);
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    state_d     = state_q;
    clr_d       = clr_q;
    cnt_d       = cnt_q;
    out_valid_d = out_valid_q;
    ram_we      = 1'b0;
    ram_addr    = q_head_i.addr;
    ram_wdata   = wr_code;
    if (out_taken) begin
      out_valid_d = 1'b0;
    end
    case (state_q)
      ST_CLR: begin
        ram_we    = 1'b1;
        ram_addr  = clr_q;
        ram_wdata = '0;
        clr_d     = clr_q + 1'b1;
        if (clr_q == mgmb_pkg::addr_t'(mgmb_pkg::MAP_DEPTH - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (q_pop_o) begin
          state_d = ST_EXE;
        end
      end
      ST_EXE: begin
        ram_we      = wr_en;
        ram_addr    = ex_q.addr;
        cnt_d       = cnt_q + mgmb_pkg::cnt_t'(bump);
        out_valid_d = 1'b1;
        state_d     = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLR;
      clr_q       <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      ex_q <= q_head_i;
    end
    if (state_q == ST_EXE) begin
      out_type_q  <= mgmb_pkg::gt_t'(old_code);
      out_wrote_q <= wr_en;
    end
  end

  assign clearing_o         = (state_q == ST_CLR);
  assign out_valid_o        = out_valid_q;
  assign out_pixel_type_o   = out_type_q;
  assign out_wrote_o        = out_wrote_q;
  assign out_change_count_o = cnt_q;

  a_write_in_map: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EXE && ram_we) |-> ex_q.in_map)
    else $error("store write outside the map");

  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q != $past(cnt_q)) |-> ($past(state_q) == ST_EXE
                                 && cnt_q == $past(cnt_q) + 32'd1))
    else $error("change counter moved by other than one step");

  a_pop_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop_o |-> (state_q == ST_IDLE && (!out_valid_q || !out_stall_i)))
    else $error("queue popped while busy");

  a_out_from_exe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> ($past(state_q) == ST_EXE))
    else $error("result loaded outside execute cycle");

endmodule

// ===== rtl/masked_ground_map_blit.sv =====
// ----------------------------------------------------------------------------
// masked_ground_map_blit: ground map with masked pixel blits
// Pixel reads, sets, mask paints and mask erases on a map of ground codes,
// with a change counter, split into a classifying front end, a short queue
// and a read-modify-write back end.
// ----------------------------------------------------------------------------
//
//  channel  | handshake              | word
//  ---------+------------------------+----------------------------------------
//  in       | in_valid_i / in_stall_o| cmd, origin x/y, offset x/y, mask bit,
//           |                        | ground type, op start
//  out      | out_valid_o/out_stall_i| pixel type, wrote, change count
//  cfg      | cfg_we_i               | cfg_index_i, cfg_data_i (map w/h)
//
//  In the back end each word has a read cycle and then a write-and-result
//  cycle on the single port of the map store, so a new word is taken only
//  after the last one is through both; an accepted word passes stage A,
//  stage B and the queue before it reaches the back end.
//  After reset the store is cleared one entry per cycle, MAX_WIDTH*MAX_HEIGHT
//  entries (1048576); in_stall_o stays high meanwhile, cfg writes still land.
//  A stalled result holds in the output register while up to four more words
//  are taken into the front pipe and queue.
//
module masked_ground_map_blit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [0:0]  cfg_index_i,
  input  logic [10:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  in_cmd_i,
  input  logic [11:0] in_origin_x_i,
  input  logic [11:0] in_origin_y_i,
  input  logic [9:0]  in_off_x_i,
  input  logic [9:0]  in_off_y_i,
  input  logic        in_mask_bit_i,
  input  logic [3:0]  in_ground_type_i,
  input  logic        in_op_start_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [3:0]  out_pixel_type_o,
  output logic        out_wrote_o,
  output logic [31:0] out_change_count_o
);

  // configuration
  logic [mgmb_pkg::DIM_W-1:0] map_w_q, map_h_q;
  mgmb_pkg::ew_x_t            eff_w;
  mgmb_pkg::ew_y_t            eff_h;

  // front / queue / back
  logic                 q_push, q_pop, q_valid, clearing;
  mgmb_pkg::q_entry_t   q_push_entry, q_head;
  mgmb_pkg::qcnt_t      q_count;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      map_w_q <= mgmb_pkg::MAP_DIM_RESET;
      map_h_q <= mgmb_pkg::MAP_DIM_RESET;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        mgmb_pkg::REG_MAP_WIDTH:  map_w_q <= cfg_data_i;
        mgmb_pkg::REG_MAP_HEIGHT: map_h_q <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  // sizes beyond the store clamp to the store
  always_comb begin
    eff_w = (32'(map_w_q) > 32'(mgmb_pkg::MAX_WIDTH))
          ? mgmb_pkg::ew_x_t'(mgmb_pkg::MAX_WIDTH) : mgmb_pkg::ew_x_t'(map_w_q);
    eff_h = (32'(map_h_q) > 32'(mgmb_pkg::MAX_HEIGHT))
          ? mgmb_pkg::ew_y_t'(mgmb_pkg::MAX_HEIGHT) : mgmb_pkg::ew_y_t'(map_h_q);
  end

  mgmb_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .in_cmd_i        (in_cmd_i),
    .in_origin_x_i   (in_origin_x_i),
    .in_origin_y_i   (in_origin_y_i),
    .in_off_x_i      (in_off_x_i),
    .in_off_y_i      (in_off_y_i),
    .in_mask_bit_i   (in_mask_bit_i),
    .in_ground_type_i(in_ground_type_i),
    .in_op_start_i   (in_op_start_i),
    .eff_w_i         (eff_w),
    .eff_h_i         (eff_h),
    .clearing_i      (clearing),
    .q_count_i       (q_count),
    .q_push_o        (q_push),
    .q_entry_o       (q_push_entry)
  );

  mgmb_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (q_push),
    .push_entry_i(q_push_entry),
    .pop_i       (q_pop),
    .valid_o     (q_valid),
    .head_o      (q_head),
    .count_o     (q_count)
  );

  mgmb_back u_back (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .q_valid_i         (q_valid),
    .q_head_i          (q_head),
    .q_pop_o           (q_pop),
    .clearing_o        (clearing),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .out_pixel_type_o  (out_pixel_type_o),
    .out_wrote_o       (out_wrote_o),
    .out_change_count_o(out_change_count_o)
  );

endmodule

// ===== sim/masked_ground_map_blit_tb.sv =====
// ----------------------------------------------------------------------------
// masked_ground_map_blit_tb: self-checking bench of the ground map blitter
// Walks a table of directed pixel words, then random noise words, reads, sets
// and well-formed mask paint/erase runs over several map sizes, and scores every
// result word against a typed-in result or a behavioral model of the map and counter.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module masked_ground_map_blit_tb;

  localparam int NUM_PHASES  = 7;
  localparam int PHASE_WORDS = 105;   // random words per map size
  localparam int TAIL_CYCLES = 20;    // drain margin: pipe, queue and back end

  // one input word and one result word as the bench sees them
  typedef struct packed {
    mgmb_pkg::cmd_e     cmd;
    logic signed [11:0] org_x;
    logic signed [11:0] org_y;
    logic [9:0]         off_x;
    logic [9:0]         off_y;
    logic               mbit;
    mgmb_pkg::gt_t      gtype;
    logic               start;
  } pixel_word_t;

  typedef struct packed {
    mgmb_pkg::gt_t  pix;
    logic           wrote;
    mgmb_pkg::cnt_t count;
  } pixel_result_t;

  // directed row: word plus, where obvious, the typed-in result
  typedef struct {
    pixel_word_t   w;
    bit            known;
    pixel_result_t res;
  } blit_row_t;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [0:0]  cfg_index_i;
  logic [10:0] cfg_data_i;
  logic        in_valid_i;
  logic        in_stall_o;
  logic [1:0]  in_cmd_i;
  logic [11:0] in_origin_x_i;
  logic [11:0] in_origin_y_i;
  logic [9:0]  in_off_x_i;
  logic [9:0]  in_off_y_i;
  logic        in_mask_bit_i;
  logic [3:0]  in_ground_type_i;
  logic        in_op_start_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic [3:0]  out_pixel_type_o;
  logic        out_wrote_o;
  logic [31:0] out_change_count_o;

  masked_ground_map_blit uut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_we_i           (cfg_we_i),
    .cfg_index_i        (cfg_index_i),
    .cfg_data_i         (cfg_data_i),
    .in_valid_i         (in_valid_i),
    .in_stall_o         (in_stall_o),
    .in_cmd_i           (in_cmd_i),
    .in_origin_x_i      (in_origin_x_i),
    .in_origin_y_i      (in_origin_y_i),
    .in_off_x_i         (in_off_x_i),
    .in_off_y_i         (in_off_y_i),
    .in_mask_bit_i      (in_mask_bit_i),
    .in_ground_type_i   (in_ground_type_i),
    .in_op_start_i      (in_op_start_i),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .out_pixel_type_o   (out_pixel_type_o),
    .out_wrote_o        (out_wrote_o),
    .out_change_count_o (out_change_count_o)
  );

  // --------------------------------------------------------------------------
  // model state: sparse copy of the map (absent entry = empty), counter,
  // raw size registers as written
  // --------------------------------------------------------------------------
  mgmb_pkg::code_t ground_map [int unsigned];
  mgmb_pkg::cnt_t  chg_count;
  int              map_w;
  int              map_h;

  pixel_result_t expected_pixels [$];
  blit_row_t     blit_table [$];

  int            fail_cnt;
  int            words_sent;
  int            results_seen;
  int            snd_idle_pct;
  int            rcv_idle_pct;

  // register values above the store size act as the store size
  function automatic int clamp_dim(int v, int m);
    return (v > m) ? m : v;
  endfunction

  // Behavior of one pixel word: old code, write flag, counter after it.
  // Updates the model map and counter.
  function automatic pixel_result_t predict_pixel(pixel_word_t w);
    int            ew;
    int            eh;
    int            ox;
    int            oy;
    int            dx;
    int            dy;
    int            px;
    int            py;
    bit            in_map;
    bit            skip;
    int unsigned   addr;
    pixel_result_t r;
    ew = clamp_dim(map_w, mgmb_pkg::MAX_WIDTH);
    eh = clamp_dim(map_h, mgmb_pkg::MAX_HEIGHT);
    ox = int'($signed(w.org_x));
    oy = int'($signed(w.org_y));
    dx = 0;
    dy = 0;
    // read and set address the origin itself; offsets are don't-care
    if (w.cmd == mgmb_pkg::CMD_PAINT || w.cmd == mgmb_pkg::CMD_ERASE) begin
      dx = int'(w.off_x);
      dy = int'(w.off_y);
    end
    px = ox + dx;
    py = oy + dy;
    in_map = (px >= 0) && (py >= 0) && (px < ew) && (py < eh);
    addr = px + py * ew;
    r.pix = mgmb_pkg::GT_OUTSIDE;
    r.wrote = 1'b0;
    if (in_map) begin
      r.pix = ground_map.exists(addr) ? ground_map[addr] : mgmb_pkg::GT_EMPTY;
    end
    case (w.cmd)
      mgmb_pkg::CMD_SET: begin
        // counts even off-map, any code including transparent
        chg_count++;
        if (in_map) begin
          ground_map[addr] = w.gtype;
          r.wrote = 1'b1;
        end
      end
      mgmb_pkg::CMD_PAINT: begin
        // origin equal to the size still paints; strictly past it does not
        skip = (w.gtype == mgmb_pkg::GT_TRANSPARENT) || !w.mbit || (ox > ew) || (oy > eh);
        // bridges only go onto empty ground inside the map
        if (!skip && w.gtype == mgmb_pkg::GT_BRIDGE
            && !(in_map && r.pix == mgmb_pkg::GT_EMPTY)) begin
          skip = 1'b1;
        end
        if (!skip) begin
          chg_count++;
          if (in_map) begin
            ground_map[addr] = w.gtype;
            r.wrote = 1'b1;
          end
        end
      end
      mgmb_pkg::CMD_ERASE: begin
        // one count per erase op, whatever its first pixel hits
        if (w.start) begin
          chg_count++;
        end
        if (w.mbit && in_map && r.pix != mgmb_pkg::GT_SOLID) begin
          ground_map[addr] = mgmb_pkg::GT_EMPTY;
          r.wrote = 1'b1;
        end
      end
      default: begin
      end
    endcase
    r.count = chg_count;
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // clock, reset, timeout
  // --------------------------------------------------------------------------
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // timeout after 40 ms, which leaves room for the store clear after reset
  initial begin
    #40_000_000;
    $display("Regression FAIL");
    $finish;
  end

  // --------------------------------------------------------------------------
  // receiver: stall toggled at the falling edge, words scored at the rising
  // --------------------------------------------------------------------------
  always @(negedge clk_i) begin
    if (rst_ni) begin
      out_stall_i <= ($urandom_range(99) < rcv_idle_pct);
    end
  end

  always @(posedge clk_i) begin : score_results
    pixel_result_t exp_r;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      results_seen++;
      if (expected_pixels.size() == 0) begin
        $error("result word with nothing expected: pixel_type %0d wrote %0d count %0d",
               out_pixel_type_o, out_wrote_o, out_change_count_o);
        fail_cnt++;
      end else begin
        exp_r = expected_pixels.pop_front();
        if (out_pixel_type_o !== exp_r.pix) begin
          $error("pixel_type: expected %0d, got %0d", exp_r.pix, out_pixel_type_o);
          fail_cnt++;
        end
        if (out_wrote_o !== exp_r.wrote) begin
          $error("wrote: expected %0d, got %0d", exp_r.wrote, out_wrote_o);
          fail_cnt++;
        end
        if (out_change_count_o !== exp_r.count) begin
          $error("change_count: expected %0d, got %0d", exp_r.count, out_change_count_o);
          fail_cnt++;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // sender
  // --------------------------------------------------------------------------

  // Drive one word from a falling edge and hold it until taken. The model
  // runs at the accepting edge so its order follows the block's.
  task automatic send_word(pixel_word_t w, bit known, pixel_result_t typed);
    pixel_result_t r;
    // idle profile: eager sender / stalling receiver, then swapped, then none
    if (words_sent < 250) begin
      snd_idle_pct = 12;
      rcv_idle_pct = 66;
    end else if (words_sent < 500) begin
      snd_idle_pct = 66;
      rcv_idle_pct = 12;
    end else begin
      snd_idle_pct = 0;
      rcv_idle_pct = 0;
    end
    while ($urandom_range(99) < snd_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_cmd_i         <= w.cmd;
    in_origin_x_i    <= w.org_x;
    in_origin_y_i    <= w.org_y;
    in_off_x_i       <= w.off_x;
    in_off_y_i       <= w.off_y;
    in_mask_bit_i    <= w.mbit;
    in_ground_type_i <= w.gtype;
    in_op_start_i    <= w.start;
    in_valid_i       <= 1'b1;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    r = predict_pixel(w);
    expected_pixels.push_back(known ? typed : r);
    words_sent++;
    @(negedge clk_i);
  endtask

  // Hold off until every pending result is back. Always waits for a falling edge
  // first so valid is never dropped and raised in the same step.
  task automatic drain_results();
    in_valid_i <= 1'b0;
    do @(negedge clk_i); while (expected_pixels.size() != 0);
  endtask

  // both size registers, back to back, with no words in flight
  task automatic write_map_size(int w, int h);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= mgmb_pkg::REG_MAP_WIDTH;
    cfg_data_i  <= w[10:0];
    @(negedge clk_i);
    cfg_index_i <= mgmb_pkg::REG_MAP_HEIGHT;
    cfg_data_i  <= h[10:0];
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    map_w = w;
    map_h = h;
  endtask

  task automatic add_row(mgmb_pkg::cmd_e c, int ox, int oy, int dx, int dy, bit mb, int gt,
                         bit st, bit known, int e_pix, bit e_wr, int e_cnt);
    blit_row_t row;
    row.w.cmd     = c;
    row.w.org_x   = ox[11:0];
    row.w.org_y   = oy[11:0];
    row.w.off_x   = dx[9:0];
    row.w.off_y   = dy[9:0];
    row.w.mbit    = mb;
    row.w.gtype   = gt[3:0];
    row.w.start   = st;
    row.known     = known;
    row.res.pix   = e_pix[3:0];
    row.res.wrote = e_wr;
    row.res.count = e_cnt;
    blit_table.push_back(row);
  endtask

  // coordinate near the map: mostly the top-left corner, some around the
  // far edge, a few anywhere in the signed range
  function automatic int pick_coord(int lim);
    int k;
    k = $urandom_range(99);
    if (k < 70) begin
      return $signed($urandom_range(clamp_dim(lim, 20) + 5)) - 3;
    end else if (k < 90) begin
      return lim - 3 + $signed($urandom_range(5));
    end
    return $signed($urandom_range(4095)) - 2048;
  endfunction

  function automatic pixel_word_t noise_word();
    pixel_word_t w;
    w.cmd   = mgmb_pkg::cmd_e'(2'($urandom_range(3)));
    w.org_x = 12'($urandom_range(4095));
    w.org_y = 12'($urandom_range(4095));
    w.off_x = 10'($urandom_range(1023));
    w.off_y = 10'($urandom_range(1023));
    w.mbit  = 1'($urandom_range(1));
    w.gtype = 4'($urandom_range(15));
    w.start = 1'($urandom_range(1));
    return w;
  endfunction

  // one mask op: start flag on its first pixel, rectangle scanned row by row
  task automatic run_mask_op(mgmb_pkg::cmd_e c);
    pixel_word_t   w;
    pixel_result_t none;
    int            mw;
    int            mh;
    int            bx;
    int            by;
    int            k;
    none = '0;
    mw = $urandom_range(4, 1);
    mh = $urandom_range(4, 1);
    bx = ($urandom_range(9) == 0) ? $urandom_range(1020) : 0;
    by = ($urandom_range(9) == 0) ? $urandom_range(1020) : 0;
    w = noise_word();
    w.cmd   = c;
    w.org_x = 12'(pick_coord(clamp_dim(map_w, mgmb_pkg::MAX_WIDTH)));
    w.org_y = 12'(pick_coord(clamp_dim(map_h, mgmb_pkg::MAX_HEIGHT)));
    k = $urandom_range(9);
    if (k < 3) begin
      w.gtype = mgmb_pkg::GT_BRIDGE;
    end else if (k == 3) begin
      w.gtype = mgmb_pkg::GT_TRANSPARENT;
    end else if (k < 6) begin
      w.gtype = mgmb_pkg::GT_SOLID;
    end
    for (int y = 0; y < mh; y++) begin
      for (int x = 0; x < mw; x++) begin
        w.off_x = 10'(bx + x);
        w.off_y = 10'(by + y);
        w.mbit  = ($urandom_range(3) != 0);
        w.start = (x == 0 && y == 0);
        send_word(w, 1'b0, none);
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // main sequence
  // --------------------------------------------------------------------------
  initial begin : stimulus
    // size settings per phase: clamped, small, one column, empty map,
    // one row, tiny, full
    int            phase_w [NUM_PHASES];
    int            phase_h [NUM_PHASES];
    int            target;
    int            k;
    pixel_word_t   w;
    pixel_result_t none;

    phase_w = '{2047, 16, 1, 0, 37, 6, 1024};
    phase_h = '{2047, 8, 1024, 5, 1, 3, 1024};
    none = '0;

    rst_ni           <= 1'b0;
    cfg_we_i         <= 1'b0;
    cfg_index_i      <= mgmb_pkg::REG_MAP_WIDTH;
    cfg_data_i       <= '0;
    in_valid_i       <= 1'b0;
    in_cmd_i         <= mgmb_pkg::CMD_READ;
    in_origin_x_i    <= '0;
    in_origin_y_i    <= '0;
    in_off_x_i       <= '0;
    in_off_y_i       <= '0;
    in_mask_bit_i    <= 1'b0;
    in_ground_type_i <= mgmb_pkg::GT_EMPTY;
    in_op_start_i    <= 1'b0;
    out_stall_i      <= 1'b0;
    fail_cnt     = 0;
    words_sent   = 0;
    results_seen = 0;
    snd_idle_pct = 0;
    rcv_idle_pct = 0;
    chg_count    = '0;
    map_w        = int'(mgmb_pkg::MAP_DIM_RESET);
    map_h        = int'(mgmb_pkg::MAP_DIM_RESET);

    // directed rows, run on the clamped 1024x1024 map; typed results where
    // they follow directly from reset state or the special case at hand
    //      cmd                 ox     oy    dx    dy   mb gt  st kn  pix wr cnt
    add_row(mgmb_pkg::CMD_READ,     0,     0,    0,    0, 0, 0, 0, 1,
            mgmb_pkg::GT_EMPTY,   0, 0);
    add_row(mgmb_pkg::CMD_READ,    -1,     0,    0,    0, 1, 9, 1, 1,
            mgmb_pkg::GT_OUTSIDE, 0, 0);
    add_row(mgmb_pkg::CMD_READ,  1023,  1023,    0,    0, 0, 0, 0, 1,
            mgmb_pkg::GT_EMPTY,   0, 0);
    // width register 2047 acts as 1024
    add_row(mgmb_pkg::CMD_READ,  1024,     0,    0,    0, 0, 0, 0, 1,
            mgmb_pkg::GT_OUTSIDE, 0, 0);
    add_row(mgmb_pkg::CMD_READ, -2048,  2047, 1023, 1023, 1, 15, 1, 1,
            mgmb_pkg::GT_OUTSIDE, 0, 0);
    add_row(mgmb_pkg::CMD_SET,   1023,  1023,    0,    0, 0, 15, 0, 1,
            mgmb_pkg::GT_EMPTY,   1, 1);
    // offsets on a read are ignored
    add_row(mgmb_pkg::CMD_READ,  1023,  1023, 1023, 1023, 1, 0, 1, 0, 0, 0, 0);
    // off-map set still counts
    add_row(mgmb_pkg::CMD_SET,     -5,     3,    0,    0, 0, 7, 0, 1,
            mgmb_pkg::GT_OUTSIDE, 0, 2);
    // set may write the transparent code
    add_row(mgmb_pkg::CMD_SET,      0,     0,    0,    0, 0, mgmb_pkg::GT_TRANSPARENT, 0, 1,
            mgmb_pkg::GT_EMPTY, 1, 3);
    add_row(mgmb_pkg::CMD_PAINT,    0,     0,    1,    0, 1, mgmb_pkg::GT_TRANSPARENT, 1, 1,
            mgmb_pkg::GT_EMPTY, 0, 3);
    add_row(mgmb_pkg::CMD_PAINT,    2,     0,    0,    0, 0, 5, 1, 1,
            mgmb_pkg::GT_EMPTY,   0, 3);
    // origin past the width: skipped; origin at the width: counted
    add_row(mgmb_pkg::CMD_PAINT, 1025,     0,    0,    0, 1, 5, 1, 1,
            mgmb_pkg::GT_OUTSIDE, 0, 3);
    add_row(mgmb_pkg::CMD_PAINT, 1024,     0,    0,    0, 1, 5, 1, 1,
            mgmb_pkg::GT_OUTSIDE, 0, 4);
    // bridge onto empty ground, then onto itself, then off-map
    add_row(mgmb_pkg::CMD_PAINT,    2,     0,    0,    0, 1, mgmb_pkg::GT_BRIDGE, 1, 1,
            mgmb_pkg::GT_EMPTY, 1, 5);
    add_row(mgmb_pkg::CMD_PAINT,    2,     0,    0,    0, 1, mgmb_pkg::GT_BRIDGE, 0, 0,
            0, 0, 0);
    add_row(mgmb_pkg::CMD_PAINT,   -1,     0,    0,    0, 1, mgmb_pkg::GT_BRIDGE, 0, 1,
            mgmb_pkg::GT_OUTSIDE, 0, 5);
    add_row(mgmb_pkg::CMD_PAINT,   -3,     0,    6,    0, 1, mgmb_pkg::GT_SOLID, 1, 1,
            mgmb_pkg::GT_EMPTY,  1, 6);
    add_row(mgmb_pkg::CMD_PAINT, 1000,  1000, 1023, 1023, 1, 15, 0, 1,
            mgmb_pkg::GT_OUTSIDE, 0, 7);
    // erase: solid survives, bridge cleared, clear mask bit ignored
    add_row(mgmb_pkg::CMD_ERASE,    3,     0,    0,    0, 1, 0, 1, 0, 0, 0, 0);
    add_row(mgmb_pkg::CMD_ERASE,    2,     0,    0,    0, 1, 0, 0, 0, 0, 0, 0);
    add_row(mgmb_pkg::CMD_ERASE, 1023,  1023,    0,    0, 0, 0, 0, 0, 0, 0, 0);
    add_row(mgmb_pkg::CMD_ERASE, -2048, -2048,   0,    0, 1, 0, 1, 1,
            mgmb_pkg::GT_OUTSIDE, 0, 9);
    add_row(mgmb_pkg::CMD_ERASE, 1023,  1000,    0,   23, 1, 0, 1, 0, 0, 0, 0);
    add_row(mgmb_pkg::CMD_READ,  1023,  1023,    0,    0, 0, 0, 0, 1, 0, 0, 10);

    repeat (9) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    for (int p = 0; p < NUM_PHASES; p++) begin
      // sizes only change with nothing in flight
      drain_results();
      write_map_size(phase_w[p], phase_h[p]);

      if (p == 0) begin
        foreach (blit_table[i]) begin
          send_word(blit_table[i].w, blit_table[i].known, blit_table[i].res);
        end
      end

      target = words_sent + PHASE_WORDS;
      while (words_sent < target) begin
        k = $urandom_range(99);
        if (k < 10) begin
          send_word(noise_word(), 1'b0, none);
        end else if (k < 35) begin
          w = noise_word();
          w.cmd   = ($urandom_range(1) != 0) ? mgmb_pkg::CMD_SET : mgmb_pkg::CMD_READ;
          w.org_x = 12'(pick_coord(clamp_dim(map_w, mgmb_pkg::MAX_WIDTH)));
          w.org_y = 12'(pick_coord(clamp_dim(map_h, mgmb_pkg::MAX_HEIGHT)));
          send_word(w, 1'b0, none);
        end else begin
          run_mask_op(($urandom_range(9) < 6) ? mgmb_pkg::CMD_PAINT : mgmb_pkg::CMD_ERASE);
        end
      end
    end

    drain_results();
    repeat (TAIL_CYCLES) @(negedge clk_i);

    $display("Covered %0d pixel words (reads, sets, mask paints, mask erases)",
             words_sent);
    $display("over %0d map sizes incl. empty and clamped; %0d scored, final count %0d",
             NUM_PHASES, results_seen, chg_count);
    if (fail_cnt == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
